// ----- hdl/vuri_pkg.sv -----
// ----------------------------------------------------------------------------
// vuri_pkg
// Request and response types and fixed constants of the video unit
// register interface.
// ----------------------------------------------------------------------------
package vuri_pkg;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_RESET  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        cmd_t       command;
        reg_idx_t   register_index;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi_level;
        logic [14:0] current_address;
        logic [2:0]  fine_scroll_x;
    } rsp_t;

    localparam logic [2:0]  STATUS_RESET   = 3'b101;
    localparam logic [7:0]  SPR_ATTR_MASK  = 8'hE3;
    localparam logic [14:0] ADDR_PALETTE   = 15'h3F00;
    localparam logic [14:0] ADDR_NT_MASK   = 15'h2FFF;
    localparam logic [14:0] STEP_ROW       = 15'd32;
    localparam logic [14:0] STEP_COL       = 15'd1;
    localparam int          SPR_DEPTH      = 256;

endpackage

// ----- hdl/vuri_ram.sv -----
// ----------------------------------------------------------------------------
// vuri_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vuri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/video_unit_register_interface_core.sv -----
// ----------------------------------------------------------------------------
// video_unit_register_interface_core
// CPU side register file of the picture unit: control, scroll and address
// latches, sprite memory and a flat video memory.
// An accepted request waits in the work stage, and its result is registered
// in the response register; a palette-area data read stays in the work
// stage while the mirrored entry is read. Throughput: one request per cycle
// unless a response stalls or a palette read holds the read port. Sprite and
// video memory reads are issued at accept time from the forwarded next state.
// Reset: asynchronous; clears state and all valid bits at once, but not the
// request, palette or response data; video memory is undefined until written.
// ----------------------------------------------------------------------------
module video_unit_register_interface_core
    import vuri_pkg::*;
#(
    parameter int VIDEO_ADDR_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int VMEM_DEPTH = 1 << VIDEO_ADDR_BITS;
    localparam logic [VIDEO_ADDR_BITS-1:0] PALETTE_START =
        ADDR_PALETTE[VIDEO_ADDR_BITS-1:0];
    localparam logic [VIDEO_ADDR_BITS-1:0] NT_MASK =
        ADDR_NT_MASK[VIDEO_ADDR_BITS-1:0];

    // architectural state
    logic [7:0]  control_reg, control_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  spr_addr_reg, spr_addr_next;
    logic [14:0] live_reg, live_next;
    logic [14:0] temp_reg, temp_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  rbuf_reg, rbuf_next;
    logic [7:0]  latch_reg, latch_next;
    logic [SPR_DEPTH-1:0] spr_valid_reg;

    // work stage
    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic        phase_reg, phase_next;
    logic [7:0]  pal_byte_reg, pal_byte_next;

    // response register
    logic        out_valid_reg;
    rsp_t        out_reg;

    // memory ports
    logic        spr_we;
    logic [7:0]  spr_wdata;
    logic [7:0]  spr_q;
    logic        vmem_we;
    logic        vmem_re;
    logic [VIDEO_ADDR_BITS-1:0] vmem_raddr;
    logic [7:0]  vmem_q;
    logic        second_re;

    logic        req_accept;
    logic        out_free;
    logic        s1_done;
    logic        need_second;
    logic [VIDEO_ADDR_BITS-1:0] vaddr;
    logic [7:0]  spr_data;
    logic [7:0]  rd;
    logic [14:0] live_adv;

    assign req_accept  = req_valid && req_ready;
    assign out_free    = !out_valid_reg || rsp_ready;
    assign vaddr       = live_reg[VIDEO_ADDR_BITS-1:0];
    assign need_second = s1_valid_reg && (s1_req_reg.command == CMD_READ)
                         && (s1_req_reg.register_index == REG_DATA)
                         && (vaddr >= PALETTE_START) && !phase_reg;
    assign s1_done     = s1_valid_reg && out_free && !need_second;
    assign req_ready   = !s1_valid_reg || s1_done;
    assign second_re   = need_second;
    assign spr_data    = spr_valid_reg[spr_addr_reg] ? spr_q : 8'h00;
    assign live_adv    = live_reg + (control_reg[2] ? STEP_ROW : STEP_COL);

    always_comb
    begin
        control_next  = control_reg;
        status_next   = status_reg;
        spr_addr_next = spr_addr_reg;
        live_next     = live_reg;
        temp_next     = temp_reg;
        fine_x_next   = fine_x_reg;
        toggle_next   = toggle_reg;
        rbuf_next     = rbuf_reg;
        latch_next    = latch_reg;
        phase_next    = phase_reg;
        pal_byte_next = pal_byte_reg;
        spr_we        = 1'b0;
        spr_wdata     = s1_req_reg.write_data;
        vmem_we       = 1'b0;
        rd            = 8'h00;

        if (need_second)
        begin
            // hold the palette byte while the mirrored entry is fetched
            pal_byte_next = vmem_q;
            phase_next    = 1'b1;
        end

        if (s1_done)
        begin
            phase_next = 1'b0;
            unique case (s1_req_reg.command)
                CMD_READ:
                begin
                    unique case (s1_req_reg.register_index)
                        REG_STATUS:
                        begin
                            rd          = {status_reg, latch_reg[4:0]};
                            status_next = {1'b0, status_reg[1:0]};
                            toggle_next = 1'b0;
                            latch_next  = rd;
                        end
                        REG_OAM_DATA:
                        begin
                            rd         = spr_data;
                            latch_next = rd;
                        end
                        REG_DATA:
                        begin
                            rd         = phase_reg ? pal_byte_reg : rbuf_reg;
                            rbuf_next  = vmem_q;
                            live_next  = live_adv;
                            latch_next = rd;
                        end
                        default:
                        begin
                            rd = latch_reg;
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    latch_next = s1_req_reg.write_data;
                    unique case (s1_req_reg.register_index)
                        REG_CTRL:
                        begin
                            control_next = s1_req_reg.write_data;
                            temp_next    = {temp_reg[14:12], s1_req_reg.write_data[1:0],
                                            temp_reg[9:0]};
                        end
                        REG_OAM_ADDR:
                        begin
                            spr_addr_next = s1_req_reg.write_data;
                        end
                        REG_OAM_DATA:
                        begin
                            spr_we = 1'b1;
                            if (spr_addr_reg[1:0] == 2'b10)
                            begin
                                spr_wdata = s1_req_reg.write_data & SPR_ATTR_MASK;
                            end
                            spr_addr_next = spr_addr_reg + 8'd1;
                        end
                        REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_next   = {temp_reg[14:5], s1_req_reg.write_data[7:3]};
                                fine_x_next = s1_req_reg.write_data[2:0];
                            end
                            else
                            begin
                                temp_next = {s1_req_reg.write_data[2:0], temp_reg[11:10],
                                             s1_req_reg.write_data[7:3], temp_reg[4:0]};
                            end
                            toggle_next = !toggle_reg;
                        end
                        REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_next = {1'b0, s1_req_reg.write_data[5:0],
                                             temp_reg[7:0]};
                            end
                            else
                            begin
                                temp_next = {temp_reg[14:8], s1_req_reg.write_data};
                                live_next = {temp_reg[14:8], s1_req_reg.write_data};
                            end
                            toggle_next = !toggle_reg;
                        end
                        REG_DATA:
                        begin
                            vmem_we   = 1'b1;
                            live_next = live_adv;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_STATUS:
                begin
                    status_next = s1_req_reg.write_data[7:5];
                end
                CMD_RESET:
                begin
                    control_next = 8'h00;
                    toggle_next  = 1'b0;
                    rbuf_next    = 8'h00;
                    live_next    = 15'd0;
                    temp_next    = 15'd0;
                    fine_x_next  = 3'd0;
                    latch_next   = 8'h00;
                end
            endcase
        end
    end

    // reads for the next request use the state as it stands after this one
    assign vmem_re    = req_accept || second_re;
    assign vmem_raddr = second_re ? (vaddr & NT_MASK) : live_next[VIDEO_ADDR_BITS-1:0];

    vuri_ram #(
        .WIDTH (8),
        .DEPTH (SPR_DEPTH)
    ) u_spr_ram (
        .clk   (clk),
        .we    (spr_we),
        .waddr (spr_addr_reg),
        .wdata (spr_wdata),
        .re    (req_accept),
        .raddr (spr_addr_next),
        .rdata (spr_q)
    );

    vuri_ram #(
        .WIDTH (8),
        .DEPTH (VMEM_DEPTH)
    ) u_vmem_ram (
        .clk   (clk),
        .we    (vmem_we),
        .waddr (vaddr),
        .wdata (s1_req_reg.write_data),
        .re    (vmem_re),
        .raddr (vmem_raddr),
        .rdata (vmem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= 8'h00;
            status_reg    <= STATUS_RESET;
            spr_addr_reg  <= 8'h00;
            live_reg      <= 15'd0;
            temp_reg      <= 15'd0;
            fine_x_reg    <= 3'd0;
            toggle_reg    <= 1'b0;
            rbuf_reg      <= 8'h00;
            latch_reg     <= 8'h00;
            spr_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            control_reg  <= control_next;
            status_reg   <= status_next;
            spr_addr_reg <= spr_addr_next;
            live_reg     <= live_next;
            temp_reg     <= temp_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            rbuf_reg     <= rbuf_next;
            latch_reg    <= latch_next;
            phase_reg    <= phase_next;
            if (spr_we)
            begin
                spr_valid_reg[spr_addr_reg] <= 1'b1;
            end
            if (req_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pal_byte_reg <= pal_byte_next;
        if (req_accept)
        begin
            s1_req_reg <= req;
        end
        if (s1_done)
        begin
            out_reg.read_data       <= rd;
            out_reg.nmi_level       <= control_next[7] && status_next[2];
            out_reg.current_address <= live_next;
            out_reg.fine_scroll_x   <= fine_x_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- hdl/vuri_checker.sv -----
// ----------------------------------------------------------------------------
// vuri_checker
// Port-level timing checks of the register interface, bound to the top level.
// ----------------------------------------------------------------------------
module vuri_checker
    import vuri_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // with nothing accepted last cycle and no response pending, take a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(req_valid && req_ready) && !rsp_valid |-> req_ready)
        else $error("request refused while idle");

    // a fresh response must follow an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2)
                             || $past(req_valid && req_ready, 3))
        else $error("response without matching request");

endmodule

bind video_unit_register_interface_core vuri_checker u_vuri_checker (.*);
